FILE: hw/rtl/qdm_pkg.sv
// ----------------------------------------------------------------------------
// qdm_pkg
// Shared types and constants for the multimode quadrature decoder.
// ----------------------------------------------------------------------------
package qdm_pkg;

   localparam int COUNT_W  = 32;
   localparam int SCALE_W  = 32;
   localparam int SCALED_W = 48;
   localparam int FRAC_W   = 16;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 1;

   typedef enum logic [1:0] {
      MODE_1X = 2'd0,
      MODE_2X = 2'd1,
      MODE_4X = 2'd2
   } decode_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DECODE_MODE  = 1'd0,
      CSR_SCALE_FACTOR = 1'd1
   } csr_index_type;

   typedef enum logic {
      FUNC_SAMPLE = 1'b0,
      FUNC_CLEAR  = 1'b1
   } func_type;

   localparam logic [1:0] PH_00 = 2'b00;
   localparam logic [1:0] PH_01 = 2'b01;
   localparam logic [1:0] PH_10 = 2'b10;
   localparam logic [1:0] PH_11 = 2'b11;

   localparam logic signed [SCALE_W-1:0] SCALE_RESET = 32'sd65536;

   typedef struct packed {
      logic func;
      logic phase_a;
      logic phase_b;
   } req_type;

   typedef struct packed {
      logic signed [COUNT_W-1:0]  position_count;
      logic signed [SCALED_W-1:0] scaled_position;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic hold;
   } stage_ctrl_type;

endpackage

FILE: hw/rtl/quadrature_decoder_multimode.sv
// ----------------------------------------------------------------------------
// quadrature_decoder_multimode
// Quadrature decoder with 1x/2x/4x modes and a Q16.16 scale factor.
//
//   channel | ports                         | beat
//   --------+-------------------------------+--------------------------------
//   req     | req_valid req_stall req_data  | func, phase_a, phase_b
//   rsp     | rsp_valid rsp_stall rsp_data  | position_count, scaled_position
//   csr     | csr_we csr_index csr_wdata    | decode_mode, scale_factor
//
// one beat per cycle sustained while req_stall stays low
// stage one holds the updated count, stage two the multiplier result
// synchronous reset: mode 4x, scale 1.0, count and previous phases zero
// req_stall rises only when both stages are full and rsp_stall is high
// ----------------------------------------------------------------------------
module quadrature_decoder_multimode (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  qdm_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output qdm_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [qdm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [qdm_pkg::CSR_W-1:0]            csr_wdata
);
   import qdm_pkg::*;

   decode_mode_type           mode_ff;
   logic signed [SCALE_W-1:0] scale_ff;
   logic                      s1_valid_ff;
   logic                      hold;
   logic                      accept;
   logic signed [COUNT_W-1:0] count;
   stage_ctrl_type            ctrl;

   assign hold      = rsp_valid && rsp_stall;
   assign req_stall = s1_valid_ff && hold;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_4X;
         scale_ff <= SCALE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DECODE_MODE: begin
               if (csr_wdata[1:0] != PH_11) begin
                  mode_ff <= decode_mode_type'(csr_wdata[1:0]);
               end
            end
            CSR_SCALE_FACTOR: begin
               scale_ff <= csr_wdata[SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   assign ctrl.valid = s1_valid_ff;
   assign ctrl.hold  = hold;

   qdm_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .mode     (mode_ff),
      .count    (count)
   );

   qdm_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .count     (count),
      .scale     (scale_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hw/rtl/qdm_decode.sv
// ----------------------------------------------------------------------------
// qdm_decode
// Phase decoder: position count per beat; previous phases on 2x/4x samples.
// ----------------------------------------------------------------------------
module qdm_decode (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     accept,
   input  qdm_pkg::req_type                         req_data,
   input  qdm_pkg::decode_mode_type                 mode,
   output logic signed [qdm_pkg::COUNT_W-1:0]       count
);
   import qdm_pkg::*;

   logic signed [COUNT_W-1:0] count_ff, count_in;
   logic [1:0]                prev_ff, prev_in;
   logic [1:0]                cur;
   logic [1:0]                diff;
   logic                      up;
   logic                      down;

   assign cur  = {req_data.phase_a, req_data.phase_b};
   assign diff = cur ^ prev_ff;

   always_comb begin
      up      = 1'b0;
      down    = 1'b0;
      prev_in = prev_ff;
      case (mode)
         MODE_1X: begin
            up   = (req_data.phase_a == req_data.phase_b);
            down = !up;
         end
         MODE_2X: begin
            up      = ((prev_ff == PH_11) && (cur == PH_00)) ||
                      ((prev_ff == PH_00) && (cur == PH_11));
            down    = ((prev_ff == PH_10) && (cur == PH_01)) ||
                      ((prev_ff == PH_01) && (cur == PH_10));
            prev_in = cur;
         end
         default: begin
            if (diff inside {PH_01, PH_10}) begin
               up   = !(prev_ff[0] ^ cur[1]);
               down = prev_ff[0] ^ cur[1];
            end
            prev_in = cur;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (req_data.func == FUNC_CLEAR) begin
         count_in = '0;
      end else if (up) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (down) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         prev_ff  <= PH_00;
      end else if (accept) begin
         count_ff <= count_in;
         if (req_data.func == FUNC_SAMPLE) begin
            prev_ff <= prev_in;
         end
      end
   end

   assign count = count_ff;

endmodule

FILE: hw/rtl/qdm_scale.sv
// ----------------------------------------------------------------------------
// qdm_scale
// Q16.16 scaling of the count and result register.
// ----------------------------------------------------------------------------
module qdm_scale (
   input  logic                                     clock,
   input  logic                                     reset,
   input  qdm_pkg::stage_ctrl_type                  ctrl,
   input  logic signed [qdm_pkg::COUNT_W-1:0]       count,
   input  logic signed [qdm_pkg::SCALE_W-1:0]       scale,
   output logic                                     rsp_valid,
   output qdm_pkg::rsp_type                         rsp_data
);
   import qdm_pkg::*;

   localparam int PROD_W = COUNT_W + SCALE_W;

   logic signed [PROD_W-1:0] product;
   logic                     valid_ff;
   rsp_type                  data_ff, data_in;

   assign product = count * scale;

   always_comb begin
      data_in.position_count  = count;
      data_in.scaled_position = product[FRAC_W +: SCALED_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!ctrl.hold) begin
         valid_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!ctrl.hold && ctrl.valid) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: test/quadrature_decoder_checker.sv
// ----------------------------------------------------------------------------
// quadrature_decoder_checker
// Watches the register port and both channels of the quadrature decoder.
// It keeps its own copy of the mode, scale, tick count and last phases,
// predicts the result of every accepted request beat, and compares each
// accepted result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module quadrature_decoder_checker
   import qdm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata,
   output int                    fail_count,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   decode_mode_type            mode_reg;
   logic signed [SCALE_W-1:0]  scale_reg;
   logic signed [COUNT_W-1:0]  tick_count;
   logic [1:0]                 last_phases;
   rsp_type                    expected_positions[$];
   int                         mismatches = 0;

   assign fail_count = mismatches;

   initial pending = 0;

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t ns: mismatch: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      rsp_type     predicted;
      rsp_type     oldest;
      logic [1:0]  cur;
      logic [1:0]  diff;
      longint      product;
      if (reset) begin
         mode_reg = MODE_4X;
         scale_reg = SCALE_RESET;
         tick_count = '0;
         last_phases = PH_00;
         expected_positions.delete();
      end else begin
         if (csr_we) begin
            if (csr_index_type'(csr_index) == CSR_DECODE_MODE) begin
               // the unused mode code leaves the register alone
               if (csr_wdata[1:0] <= MODE_4X)
                  mode_reg = decode_mode_type'(csr_wdata[1:0]);
            end else begin
               scale_reg = csr_wdata[SCALE_W-1:0];
            end
         end

         if (req_valid && !req_stall) begin
            cur = {req_data.phase_a, req_data.phase_b};
            if (req_data.func == FUNC_CLEAR) begin
               tick_count = '0;
            end else begin
               case (mode_reg)
                  MODE_1X: begin
                     tick_count = (cur[1] == cur[0]) ? tick_count + 1 : tick_count - 1;
                  end
                  MODE_2X: begin
                     if ((last_phases == PH_11 && cur == PH_00) ||
                         (last_phases == PH_00 && cur == PH_11))
                        tick_count = tick_count + 1;
                     else if ((last_phases == PH_10 && cur == PH_01) ||
                              (last_phases == PH_01 && cur == PH_10))
                        tick_count = tick_count - 1;
                     last_phases = cur;
                  end
                  default: begin
                     diff = cur ^ last_phases;
                     if (diff == PH_01 || diff == PH_10)
                        tick_count = (last_phases[0] ^ cur[1]) ? tick_count - 1
                                                               : tick_count + 1;
                     last_phases = cur;
                  end
               endcase
            end
            product = longint'(tick_count) * longint'(scale_reg);
            predicted.position_count = tick_count;
            predicted.scaled_position = product[63:16];
            expected_positions.push_back(predicted);
         end

         if (rsp_valid && !rsp_stall) begin
            if (expected_positions.size() == 0) begin
               report_mismatch("result beat with no prediction waiting");
            end else begin
               oldest = expected_positions.pop_front();
               if (rsp_data.position_count !== oldest.position_count)
                  report_mismatch($sformatf("position_count %0d, expected %0d",
                                            rsp_data.position_count,
                                            oldest.position_count));
               if (rsp_data.scaled_position !== oldest.scaled_position)
                  report_mismatch($sformatf("scaled_position %0d, expected %0d",
                                            rsp_data.scaled_position,
                                            oldest.scaled_position));
            end
         end
      end
      pending <= expected_positions.size();
   end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the multimode quadrature decoder. A short directed run covers
// reset settings, every mode, the ignored mode code, scale extremes, double
// jumps, repeats and clears; then random encoder walks with noise and clears
// run under several register settings and changing idle patterns, including
// one long receiver hold-off. The checker module does all prediction.
// ----------------------------------------------------------------------------
module tb;
   import qdm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         QUIET_LIMIT = 2000;
   localparam int         HOLD_CYCLES = 150;
   localparam int         HOLD_AT     = 100;
   localparam int         WALK_ITEMS  = 175;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_W-1:0]      csr_wdata = '0;

   int                    fail_count;
   int                    pending;
   int                    send_idle_pct = 15;
   int                    recv_idle_pct = 45;
   int                    rsp_beats = 0;
   int                    hold_left = 0;
   bit                    hold_done = 1'b0;
   int                    quiet_cycles = 0;

   decode_mode_type       active_mode = MODE_4X;
   logic [1:0]            walk_idx = 2'd0;
   bit                    walk_up = 1'b1;

   always #10 clock = ~clock;

   quadrature_decoder_multimode DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   quadrature_decoder_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            rsp_beats <= rsp_beats + 1;
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (!hold_done && rsp_beats >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic offer(input func_type f, input logic a, input logic b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{func: f, phase_a: a, phase_b: b};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_regs(input logic [1:0] mode, input logic [CSR_W-1:0] scale);
      req_valid <= 1'b0;
      drain_results();
      csr_we <= 1'b1;
      csr_index <= CSR_DECODE_MODE;
      csr_wdata <= CSR_W'(mode);
      @(posedge clock);
      csr_index <= CSR_SCALE_FACTOR;
      csr_wdata <= scale;
      @(posedge clock);
      csr_we <= 1'b0;
      if (mode != MODE_UNUSED)
         active_mode = decode_mode_type'(mode);
   endtask

   // mostly gray-code walks, some repeats, noise and clears
   task automatic walk_encoder();
      int          pick;
      logic [1:0]  stride;
      pick = $urandom_range(99);
      if (pick < 3) begin
         offer(FUNC_CLEAR, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
         if (pick < 12) begin
            walk_idx = 2'($urandom_range(3));
         end else if (pick >= 20) begin
            if ($urandom_range(9) == 0)
               walk_up = !walk_up;
            stride = (active_mode == MODE_2X && $urandom_range(1)) ? 2'd2 : 2'd1;
            walk_idx = walk_up ? walk_idx + stride : walk_idx - stride;
         end
         offer(FUNC_SAMPLE, walk_idx[1], walk_idx[1] ^ walk_idx[0]);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 4x, unity scale
      offer(FUNC_SAMPLE, 1'b0, 1'b0);
      offer(FUNC_SAMPLE, 1'b0, 1'b1);
      offer(FUNC_SAMPLE, 1'b1, 1'b1);
      offer(FUNC_SAMPLE, 1'b1, 1'b0);
      offer(FUNC_SAMPLE, 1'b0, 1'b0);
      offer(FUNC_SAMPLE, 1'b1, 1'b0);
      offer(FUNC_SAMPLE, 1'b1, 1'b1);
      offer(FUNC_SAMPLE, 1'b0, 1'b0);
      offer(FUNC_CLEAR, 1'b1, 1'b1);

      program_regs(MODE_2X, 32'h7FFF_FFFF);
      offer(FUNC_SAMPLE, 1'b1, 1'b1);
      offer(FUNC_SAMPLE, 1'b0, 1'b0);
      offer(FUNC_SAMPLE, 1'b1, 1'b0);
      offer(FUNC_SAMPLE, 1'b0, 1'b1);
      offer(FUNC_SAMPLE, 1'b1, 1'b0);
      offer(FUNC_SAMPLE, 1'b1, 1'b1);

      program_regs(MODE_1X, 32'h8000_0000);
      offer(FUNC_SAMPLE, 1'b0, 1'b0);
      offer(FUNC_SAMPLE, 1'b1, 1'b1);
      offer(FUNC_SAMPLE, 1'b0, 1'b1);
      offer(FUNC_SAMPLE, 1'b1, 1'b0);
      offer(FUNC_CLEAR, 1'b0, 1'b0);

      program_regs(MODE_UNUSED, 32'h0000_0000);
      offer(FUNC_SAMPLE, 1'b1, 1'b1);
      program_regs(MODE_1X, 32'hFFFF_FFFF);
      offer(FUNC_SAMPLE, 1'b0, 1'b1);
      offer(FUNC_SAMPLE, 1'b0, 1'b1);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: program_regs(MODE_4X, 32'h0001_0000);
            1: program_regs(MODE_2X, $urandom);
            2: program_regs(MODE_1X, 32'hFFFF_0000);
            3: program_regs(MODE_4X, 32'h8000_0000);
            4: program_regs(MODE_UNUSED, 32'h7FFF_FFFF);
            default: program_regs(MODE_2X, $urandom);
         endcase
         if (phase == 2) begin
            send_idle_pct <= 45;
            recv_idle_pct <= 15;
         end else if (phase == 4) begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end
         repeat (WALK_ITEMS) walk_encoder();
      end

      req_valid <= 1'b0;
      drain_results();
      if (fail_count == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
